FILE: sv/sync_word_length_deframer_core_defines.svh
// Assertion macros used by the deframer core.
`ifndef SYNC_WORD_LENGTH_DEFRAMER_CORE_DEFINES_SVH
`define SYNC_WORD_LENGTH_DEFRAMER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define SWLD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define SWLD_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define SWLD_ASSERT(label, clk, rst, prop)
`define SWLD_NEVER(label, clk, rst, cond)
`endif
`endif

FILE: sv/swld_pkg.sv
// Shared types and constants of the sync word deframer.
package swld_pkg;

   localparam logic [63:0] SYNC_RESET_VALUE = 64'h0708_0506_0304_0102;
   localparam int          SYNC_BYTES       = 8;
   localparam int          EMIT_W           = $clog2(SYNC_BYTES);
   localparam logic [31:0] HEADER_MIN_COUNT = 32'd16;
   localparam logic [31:0] LENGTH_OFFSET    = 32'd12;
   localparam logic [31:0] LENGTH_END       = 32'd16;
   localparam logic [31:0] START_COUNT      = 32'd8;

   typedef enum logic [1:0] {
      CELL_HOLD  = 2'd0,
      CELL_SHIFT = 2'd1,
      CELL_LOAD  = 2'd2
   } cell_op_type;

   typedef struct packed {
      logic        collecting;
      logic        last;
      logic [31:0] length;
   } frame_stat_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        frame_first;
      logic        frame_last;
      logic [31:0] declared_length;
   } rsp_type;

endpackage

FILE: sv/sync_word_length_deframer_core.sv
// A request's first result is registered in the output buffer when it is accepted.
// Throughput: one byte per cycle while hunting or collecting and the output buffer
// has room; a sync match sends its first pattern byte directly and the other seven
// through the cell chain, and the request port is held off until all are pushed.
// A two-entry output buffer lets requests flow while one result waits.
// Synchronous reset returns to hunting with an empty window and the default pattern.
`include "sync_word_length_deframer_core_defines.svh"
module sync_word_length_deframer_core
   import swld_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [63:0] csr_wr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_frame_first,
   output logic        rsp_frame_last,
   output logic [31:0] rsp_declared_length
);

   logic [63:0]       pattern_ff;
   logic [EMIT_W-1:0] emit_cnt_ff, emit_cnt_in;
   logic              main_valid_ff, main_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   rsp_type           main_ff, main_in;
   rsp_type           skid_ff, skid_in;

   frame_stat_type    stat;
   cell_op_type       cell_op;
   logic [7:0]        cell_byte [SYNC_BYTES];
   logic [7:0]        cell_shift [SYNC_BYTES];
   logic [7:0]        cell_load [SYNC_BYTES];
   logic [SYNC_BYTES-1:0] cell_match;

   logic    emitting, out_room, accept, hunt_acc, coll_acc, sync_hit, emit_push, push, pop;
   rsp_type push_data;

   assign emitting  = (emit_cnt_ff != '0);
   assign out_room  = !skid_valid_ff;
   assign req_ready = out_room && !emitting;
   assign accept    = req_valid && req_ready;
   assign hunt_acc  = accept && !stat.collecting;
   assign coll_acc  = accept && stat.collecting;
   assign sync_hit  = hunt_acc && (&cell_match);
   assign emit_push = emitting && out_room;
   assign push      = sync_hit || coll_acc || emit_push;
   assign pop       = main_valid_ff && rsp_ready;

   always_comb begin
      if (sync_hit) begin
         cell_op = CELL_LOAD;
      end else if (emit_push || hunt_acc) begin
         cell_op = CELL_SHIFT;
      end else begin
         cell_op = CELL_HOLD;
      end
   end

   // Cell k sees window byte k; the newest byte enters at the top cell.
   // After a match the chain drains toward cell 0 and is left all zero.
   genvar k;
   generate
      for (k = 0; k < SYNC_BYTES; k++) begin : g_cell
         if (k == SYNC_BYTES - 1) begin : g_top
            assign cell_shift[k] = emitting ? 8'd0 : req_rx_byte;
            assign cell_load[k]  = 8'd0;
         end else begin : g_mid
            assign cell_shift[k] = cell_byte[k+1];
            assign cell_load[k]  = pattern_ff[8*(k+1) +: 8];
         end
         swld_cell u_cell (
            .clock        (clock),
            .reset        (reset),
            .op           (cell_op),
            .shift_in     (cell_shift[k]),
            .load_byte    (cell_load[k]),
            .pattern_byte (pattern_ff[8*k +: 8]),
            .byte_out     (cell_byte[k]),
            .match        (cell_match[k])
         );
      end
   endgenerate

   swld_frame u_frame (
      .clock   (clock),
      .reset   (reset),
      .start   (sync_hit),
      .step    (coll_acc),
      .rx_byte (req_rx_byte),
      .stat    (stat)
   );

   always_comb begin
      if (emit_push) begin
         push_data = '{data_byte: cell_byte[0], frame_first: 1'b0, frame_last: 1'b0,
                       declared_length: 32'd0};
      end else if (sync_hit) begin
         push_data = '{data_byte: pattern_ff[7:0], frame_first: 1'b1, frame_last: 1'b0,
                       declared_length: 32'd0};
      end else begin
         push_data = '{data_byte: req_rx_byte, frame_first: 1'b0, frame_last: stat.last,
                       declared_length: stat.last ? stat.length : 32'd0};
      end

      emit_cnt_in = emit_cnt_ff;
      if (sync_hit) begin
         emit_cnt_in = EMIT_W'(SYNC_BYTES - 1);
      end else if (emit_push) begin
         emit_cnt_in = emit_cnt_ff - 1'b1;
      end

      main_valid_in = main_valid_ff;
      main_in       = main_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
            if (push) begin
               skid_in       = push_data;
               skid_valid_in = 1'b1;
            end
         end else begin
            main_valid_in = push;
            main_in       = push_data;
         end
      end else if (push) begin
         if (main_valid_ff) begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end else begin
            main_in       = push_data;
            main_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff    <= SYNC_RESET_VALUE;
         emit_cnt_ff   <= '0;
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            pattern_ff <= csr_wr_data;
         end
         emit_cnt_ff   <= emit_cnt_in;
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid           = main_valid_ff;
   assign rsp_data_byte       = main_ff.data_byte;
   assign rsp_frame_first     = main_ff.frame_first;
   assign rsp_frame_last      = main_ff.frame_last;
   assign rsp_declared_length = main_ff.declared_length;

   `SWLD_ASSERT(a_hit_starts_emit, clock, reset,
      sync_hit |=> (emit_cnt_ff == EMIT_W'(SYNC_BYTES - 1)) && stat.collecting)
   `SWLD_NEVER(a_skid_without_main, clock, reset, skid_valid_ff && !main_valid_ff)
   `SWLD_ASSERT(a_chain_clear_after_emit, clock, reset,
      (!$past(reset) && $past(emit_cnt_ff) != '0 && emit_cnt_ff == '0) |->
         (cell_byte[SYNC_BYTES-1] == 8'd0 && cell_byte[1] == 8'd0))
   `SWLD_NEVER(a_last_outside_frame, clock, reset, stat.last && !stat.collecting)

endmodule

FILE: sv/swld_cell.sv
// One byte cell of the sync window and emit shift chain.
module swld_cell
   import swld_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cell_op_type op,
   input  logic [7:0]  shift_in,
   input  logic [7:0]  load_byte,
   input  logic [7:0]  pattern_byte,
   output logic [7:0]  byte_out,
   output logic        match
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in;

   // The byte about to enter this cell is the window byte it checks.
   assign match    = (shift_in == pattern_byte);
   assign byte_out = byte_ff;

   always_comb begin
      case (op)
         CELL_HOLD:  byte_in = byte_ff;
         CELL_SHIFT: byte_in = shift_in;
         CELL_LOAD:  byte_in = load_byte;
         default:    byte_in = byte_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= 8'd0;
      end else begin
         byte_ff <= byte_in;
      end
   end

endmodule

FILE: sv/swld_frame.sv
// Frame byte counter and length field capture.
module swld_frame
   import swld_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic           step,
   input  logic [7:0]     rx_byte,
   output frame_stat_type stat
);

   logic        collecting_ff, collecting_in;
   logic [31:0] count_ff, count_in;
   logic [31:0] length_ff, length_in;
   logic [31:0] length_upd;
   logic [31:0] count_next;
   logic        last;

   always_comb begin
      length_upd = length_ff;
      if (step && count_ff >= LENGTH_OFFSET && count_ff < LENGTH_END) begin
         case (count_ff[1:0])
            2'd0:    length_upd[7:0]   = length_ff[7:0]   | rx_byte;
            2'd1:    length_upd[15:8]  = length_ff[15:8]  | rx_byte;
            2'd2:    length_upd[23:16] = length_ff[23:16] | rx_byte;
            2'd3:    length_upd[31:24] = length_ff[31:24] | rx_byte;
            default: length_upd = length_ff;
         endcase
      end
      // The count saturates so that a huge length still ends the frame.
      count_next = (&count_ff) ? count_ff : count_ff + 32'd1;
      last = step && (count_next >= HEADER_MIN_COUNT) && (count_next >= length_upd);

      collecting_in = collecting_ff;
      count_in      = count_ff;
      length_in     = length_ff;
      if (start) begin
         collecting_in = 1'b1;
         count_in      = START_COUNT;
         length_in     = 32'd0;
      end else if (last) begin
         collecting_in = 1'b0;
         count_in      = 32'd0;
         length_in     = 32'd0;
      end else if (step) begin
         count_in  = count_next;
         length_in = length_upd;
      end
   end

   assign stat.collecting = collecting_ff;
   assign stat.last       = last;
   assign stat.length     = length_upd;

   always_ff @(posedge clock) begin
      if (reset) begin
         collecting_ff <= 1'b0;
         count_ff      <= 32'd0;
         length_ff     <= 32'd0;
      end else begin
         collecting_ff <= collecting_in;
         count_ff      <= count_in;
         length_ff     <= length_in;
      end
   end

endmodule

FILE: sim/swld_checker.sv
// Checker for the sync word deframer: watches both channels, predicts each byte and compares.
module swld_checker
   import swld_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [63:0] csr_wr_data,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_data_byte,
   input  logic        rsp_frame_first,
   input  logic        rsp_frame_last,
   input  logic [31:0] rsp_declared_length,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 10;

   logic [63:0] sync_word;
   logic        collecting;
   logic [55:0] history;
   logic [31:0] byte_count;
   logic [31:0] length_acc;
   rsp_type     bytes_due[$];
   int          mismatches;

   // Works out the frame bytes that one accepted request delivers.
   task automatic deframe_byte(input logic [7:0] b);
      logic [63:0] window;
      logic [31:0] next_count;
      rsp_type     r;
      int          k;
      if (!collecting) begin
         window = {b, history};
         if (window == sync_word) begin
            for (k = 0; k < SYNC_BYTES; k++) begin
               r.data_byte       = sync_word[8*k +: 8];
               r.frame_first     = (k == 0);
               r.frame_last      = 1'b0;
               r.declared_length = '0;
               bytes_due.push_back(r);
            end
            collecting = 1'b1;
            byte_count = START_COUNT;
            length_acc = '0;
            history    = '0;
         end else begin
            history = window[63:8];
         end
      end else begin
         if (byte_count >= LENGTH_OFFSET && byte_count < LENGTH_END)
            length_acc = length_acc | ({24'd0, b} << (8 * (byte_count - LENGTH_OFFSET)));
         next_count = (byte_count == 32'hFFFF_FFFF) ? byte_count : byte_count + 32'd1;
         byte_count = next_count;
         r.data_byte   = b;
         r.frame_first = 1'b0;
         if (next_count >= HEADER_MIN_COUNT && next_count >= length_acc) begin
            r.frame_last      = 1'b1;
            r.declared_length = length_acc;
            collecting = 1'b0;
            history    = '0;
            byte_count = '0;
            length_acc = '0;
         end else begin
            r.frame_last      = 1'b0;
            r.declared_length = '0;
         end
         bytes_due.push_back(r);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         sync_word  = SYNC_RESET_VALUE;
         collecting = 1'b0;
         history    = '0;
         byte_count = '0;
         length_acc = '0;
         bytes_due.delete();
      end else begin
         if (csr_wr_en)
            sync_word = csr_wr_data;
         if (rsp_valid && rsp_ready) begin
            if (bytes_due.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("%0t: unexpected byte %h first %b last %b length %h", $realtime,
                           rsp_data_byte, rsp_frame_first, rsp_frame_last,
                           rsp_declared_length);
            end else begin
               want = bytes_due.pop_front();
               if (rsp_data_byte !== want.data_byte || rsp_frame_first !== want.frame_first ||
                   rsp_frame_last !== want.frame_last ||
                   rsp_declared_length !== want.declared_length) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display("%0t: expected byte %h first %b last %b length %h, got %h %b %b %h",
                              $realtime, want.data_byte, want.frame_first, want.frame_last,
                              want.declared_length, rsp_data_byte, rsp_frame_first,
                              rsp_frame_last, rsp_declared_length);
               end
            end
         end
         if (req_valid && req_ready)
            deframe_byte(req_rx_byte);
      end
      // Registered so that the stimulus sees a settled value after each edge.
      fail_count <= mismatches;
      pending    <= bytes_due.size();
   end

endmodule

FILE: sim/tb_top.sv
// Top of the deframer testbench: clock, reset, stimulus, receiver and verdict.
module tb_top
   import swld_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HOLD_CYCLES  = 80;
   localparam int SETTLE_CYCLES = 16;
   localparam int PHASE_ITEMS  = 20;
   localparam int STALL_AT     = 50;
   localparam longint unsigned NO_CAP = 64'hFFFF_FFFF_FFFF;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [63:0] csr_wr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_data_byte;
   logic        rsp_frame_first;
   logic        rsp_frame_last;
   logic [31:0] rsp_declared_length;
   int          fail_count;
   int          pending;

   bit          calm = 1'b0;
   int          items_sent = 0;

   always #4 clock = ~clock;

   sync_word_length_deframer_core DUT (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_data_byte       (rsp_data_byte),
      .rsp_frame_first     (rsp_frame_first),
      .rsp_frame_last      (rsp_frame_last),
      .rsp_declared_length (rsp_declared_length)
   );

   swld_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_data_byte       (rsp_data_byte),
      .rsp_frame_first     (rsp_frame_first),
      .rsp_frame_last      (rsp_frame_last),
      .rsp_declared_length (rsp_declared_length),
      .fail_count          (fail_count),
      .pending             (pending)
   );

   function automatic bit idle_now();
      return !calm && ($urandom_range(99) < 23);
   endfunction

   // Mostly short frames, now and then a longer one.
   function automatic logic [31:0] pick_length();
      int r;
      r = $urandom_range(99);
      if (r < 85)
         return $urandom_range(40);
      else
         return $urandom_range(80, 41);
   endfunction

   // Valid is left high after acceptance; the next request or a drain decides.
   task automatic send_byte(input logic [7:0] b);
      while (idle_now()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_sync(input logic [63:0] pattern);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= pattern;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Sends the sync bytes from sync_from on, then the frame body with the length at 12..15.
   task automatic send_frame(input logic [63:0] pattern, input int sync_from,
                             input logic [31:0] len, input longint unsigned cap);
      longint unsigned stop;
      longint unsigned idx;
      for (idx = 64'(sync_from); idx < SYNC_BYTES; idx++)
         send_byte(pattern[8*idx +: 8]);
      stop = (len > HEADER_MIN_COUNT) ? 64'(len) : 64'(HEADER_MIN_COUNT);
      if (stop > cap)
         stop = cap;
      for (idx = SYNC_BYTES; idx < stop; idx++) begin
         if (idx >= LENGTH_OFFSET && idx < LENGTH_END)
            send_byte(len[8*(idx - LENGTH_OFFSET) +: 8]);
         else
            send_byte(8'($urandom_range(255)));
      end
   endtask

   task automatic random_mix(input logic [63:0] pattern, input int target);
      int start;
      int r;
      int n;
      int k;
      start = items_sent;
      while (items_sent - start < target) begin
         r = $urandom_range(99);
         if (r < 65) begin
            send_frame(pattern, 0, pick_length(), NO_CAP);
         end else if (r < 82) begin
            n = $urandom_range(4, 1);
            for (k = 0; k < n; k++)
               send_byte(8'($urandom_range(255)));
         end else begin
            // A sync prefix broken by one wrong byte.
            n = $urandom_range(7, 1);
            for (k = 0; k < n; k++)
               send_byte(pattern[8*k +: 8]);
            send_byte(pattern[8*n +: 8] ^ 8'($urandom_range(255, 1)));
         end
      end
   endtask

   // The receiver holds off once, long enough for the block to fill and stall its input.
   initial begin
      bit stall_done;
      stall_done = 1'b0;
      forever begin
         @(posedge clock);
         if (!stall_done && items_sent >= STALL_AT) begin
            stall_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_ready <= !idle_now();
         end
      end
   end

   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      logic [63:0] pattern;
      int          phase;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Default pattern straight after reset, with a length below the header size.
      send_frame(SYNC_RESET_VALUE, 0, 32'd0, NO_CAP);
      drain();
      // The history is clear after a frame, so a pattern with zero leading bytes
      // matches on its last byte alone.
      write_sync(64'h5A00_0000_0000_0000);
      send_frame(64'h5A00_0000_0000_0000, 7, 32'd17, NO_CAP);
      drain();
      write_sync(64'h0);
      send_frame(64'h0, 7, 32'd20, NO_CAP);
      drain();

      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: pattern = {$urandom, $urandom};
            1: pattern = 64'hFFFF_FFFF_FFFF_FFFF;
            default: pattern = SYNC_RESET_VALUE;
         endcase
         write_sync(pattern);
         if (phase == 2)
            calm = 1'b1;
         random_mix(pattern, PHASE_ITEMS);
         drain();
         calm = 1'b0;
      end

      // A frame whose length cannot be reached in this run stays open to the end.
      pattern = {$urandom, $urandom};
      write_sync(pattern);
      send_frame(pattern, 0, 32'hFFFF_FFFF, 24);
      drain();

      if (fail_count == 0 && pending == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

FILE: files.f
+incdir+sv
sv/swld_pkg.sv
sv/swld_cell.sv
sv/swld_frame.sv
sv/sync_word_length_deframer_core.sv
sim/swld_checker.sv
sim/tb_top.sv
